// ===== design/bcvp_pkg.sv =====
// Package for the two-dimensional Babai rounding block.
// Holds widths and the result item type; depends on nothing else.
`default_nettype none

package bcvp_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
   localparam int DIFF_WIDTH  = 2 * COORD_WIDTH + 1;
   localparam int QUOT_WIDTH  = DIFF_WIDTH;
   localparam int COEF_WIDTH  = 2 * COORD_WIDTH + 3;
   localparam int TERM_WIDTH  = COEF_WIDTH + COORD_WIDTH;
   localparam int POINT_WIDTH = 3 * COORD_WIDTH + 4;
   localparam int CSR_WIDTH   = 2;

   typedef enum logic [CSR_WIDTH-1:0] {
      CSR_BASIS1_X = 2'd0,
      CSR_BASIS1_Y = 2'd1,
      CSR_BASIS2_X = 2'd2,
      CSR_BASIS2_Y = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0]  coef_first;
      logic signed [COEF_WIDTH-1:0]  coef_second;
      logic signed [POINT_WIDTH-1:0] point_x;
      logic signed [POINT_WIDTH-1:0] point_y;
      logic                          singular;
   } result_type;

endpackage

`default_nettype wire

// ===== design/babai_rounding_cvp_2d.sv =====
// Top level of the two-dimensional Babai rounding block.
// Depends on bcvp_pkg for widths and the result item type.
`default_nettype none

// Takes one target item per cycle while the output queue has room and
// returns one result item per target, in order. The pipeline is the
// bit-serial pipelined divider (one quotient bit per stage, 33 stages),
// plus three stages in front for the products, differences and
// magnitudes and three behind for sign, products and sums.
// A two-entry output queue holds results; the input is ready while that
// queue has room. Basis registers must only be written while the block is idle.
module babai_rounding_cvp_2d (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire logic signed [bcvp_pkg::COORD_WIDTH-1:0]  req_target_x,
   input  wire logic signed [bcvp_pkg::COORD_WIDTH-1:0]  req_target_y,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output logic signed [bcvp_pkg::COEF_WIDTH-1:0]        rsp_coef_first,
   output logic signed [bcvp_pkg::COEF_WIDTH-1:0]        rsp_coef_second,
   output logic signed [bcvp_pkg::POINT_WIDTH-1:0]       rsp_point_x,
   output logic signed [bcvp_pkg::POINT_WIDTH-1:0]       rsp_point_y,
   output logic                                          rsp_singular,
   input  wire logic                                     csr_we,
   input  wire logic [bcvp_pkg::CSR_WIDTH-1:0]           csr_index,
   input  wire logic [bcvp_pkg::COORD_WIDTH-1:0]         csr_wdata
);
   import bcvp_pkg::*;

   logic signed [COORD_WIDTH-1:0] b1x_ff, b1y_ff, b2x_ff, b2y_ff;

   logic en;

   logic                         s1_v_ff;
   logic signed [PROD_WIDTH-1:0] p_txby_ff, p_tybx_ff, p_axty_ff, p_aytx_ff;
   logic signed [PROD_WIDTH-1:0] p_axby_ff, p_aybx_ff;

   logic                         s2_v_ff;
   logic signed [DIFF_WIDTH-1:0] n1_ff, n2_ff, det_ff;

   logic [DIFF_WIDTH-1:0]        mag_n1, mag_n2, mag_det;
   logic [DIFF_WIDTH-1:0]        num1_in, num2_in, den_in;

   logic                  dv_v_ff   [0:QUOT_WIDTH];
   logic [DIFF_WIDTH-1:0] rem1_ff   [0:QUOT_WIDTH];
   logic [DIFF_WIDTH-1:0] rem2_ff   [0:QUOT_WIDTH];
   logic [DIFF_WIDTH-1:0] num1_ff   [0:QUOT_WIDTH];
   logic [DIFF_WIDTH-1:0] num2_ff   [0:QUOT_WIDTH];
   logic [QUOT_WIDTH-1:0] quo1_ff   [0:QUOT_WIDTH];
   logic [QUOT_WIDTH-1:0] quo2_ff   [0:QUOT_WIDTH];
   logic [DIFF_WIDTH-1:0] den_ff    [0:QUOT_WIDTH];
   logic                  neg1_ff   [0:QUOT_WIDTH];
   logic                  neg2_ff   [0:QUOT_WIDTH];
   logic                  sing_ff   [0:QUOT_WIDTH];

   logic [DIFF_WIDTH-1:0] rem1_in [0:QUOT_WIDTH-1];
   logic [DIFF_WIDTH-1:0] rem2_in [0:QUOT_WIDTH-1];
   logic                  bit1_in [0:QUOT_WIDTH-1];
   logic                  bit2_in [0:QUOT_WIDTH-1];

   logic                         c_v_ff, c_sing_ff;
   logic signed [COEF_WIDTH-1:0] c1_ff, c2_ff;
   logic [COEF_WIDTH-1:0]        q1_ext, q2_ext;

   logic                         m_v_ff, m_sing_ff;
   logic signed [COEF_WIDTH-1:0] m_c1_ff, m_c2_ff;
   logic signed [TERM_WIDTH-1:0] t1x_ff, t2x_ff, t1y_ff, t2y_ff;

   logic                         f_v_ff;
   result_type                   f_res_ff;

   result_type  fifo_ff [0:1];
   logic        wptr_ff, rptr_ff;
   logic [1:0]  cnt_ff;
   logic        push, pop;
   result_type  head;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1x_ff <= COORD_WIDTH'(1);
         b1y_ff <= '0;
         b2x_ff <= '0;
         b2y_ff <= COORD_WIDTH'(1);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BASIS1_X: b1x_ff <= csr_wdata;
            CSR_BASIS1_Y: b1y_ff <= csr_wdata;
            CSR_BASIS2_X: b2x_ff <= csr_wdata;
            CSR_BASIS2_Y: b2y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign en        = (cnt_ff != 2'd2);
   assign req_ready = en;

   always_comb begin
      mag_n1  = n1_ff[DIFF_WIDTH-1]  ? DIFF_WIDTH'(-n1_ff)  : DIFF_WIDTH'(n1_ff);
      mag_n2  = n2_ff[DIFF_WIDTH-1]  ? DIFF_WIDTH'(-n2_ff)  : DIFF_WIDTH'(n2_ff);
      mag_det = det_ff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-det_ff) : DIFF_WIDTH'(det_ff);
      num1_in = (mag_n1 << 1) + mag_det;
      num2_in = (mag_n2 << 1) + mag_det;
      den_in  = mag_det << 1;
   end

   always_comb begin
      logic [DIFF_WIDTH:0] t1, t2, d;
      for (int k = 0; k < QUOT_WIDTH; k++) begin
         d  = {1'b0, den_ff[k]};
         t1 = {rem1_ff[k], num1_ff[k][DIFF_WIDTH-1]};
         t2 = {rem2_ff[k], num2_ff[k][DIFF_WIDTH-1]};
         bit1_in[k] = (t1 >= d);
         bit2_in[k] = (t2 >= d);
         rem1_in[k] = bit1_in[k] ? DIFF_WIDTH'(t1 - d) : DIFF_WIDTH'(t1);
         rem2_in[k] = bit2_in[k] ? DIFF_WIDTH'(t2 - d) : DIFF_WIDTH'(t2);
      end
   end

   assign q1_ext = {2'b00, quo1_ff[QUOT_WIDTH]};
   assign q2_ext = {2'b00, quo2_ff[QUOT_WIDTH]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         for (int k = 0; k <= QUOT_WIDTH; k++) begin
            dv_v_ff[k] <= 1'b0;
         end
         c_v_ff <= 1'b0;
         m_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff    <= req_valid;
         s2_v_ff    <= s1_v_ff;
         dv_v_ff[0] <= s2_v_ff;
         for (int k = 0; k < QUOT_WIDTH; k++) begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
         c_v_ff <= dv_v_ff[QUOT_WIDTH];
         m_v_ff <= c_v_ff;
         f_v_ff <= m_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_txby_ff <= req_target_x * b2y_ff;
         p_tybx_ff <= req_target_y * b2x_ff;
         p_axty_ff <= b1x_ff * req_target_y;
         p_aytx_ff <= b1y_ff * req_target_x;
         p_axby_ff <= b1x_ff * b2y_ff;
         p_aybx_ff <= b1y_ff * b2x_ff;

         n1_ff  <= DIFF_WIDTH'(p_txby_ff) - DIFF_WIDTH'(p_tybx_ff);
         n2_ff  <= DIFF_WIDTH'(p_axty_ff) - DIFF_WIDTH'(p_aytx_ff);
         det_ff <= DIFF_WIDTH'(p_axby_ff) - DIFF_WIDTH'(p_aybx_ff);

         rem1_ff[0] <= '0;
         rem2_ff[0] <= '0;
         num1_ff[0] <= num1_in;
         num2_ff[0] <= num2_in;
         quo1_ff[0] <= '0;
         quo2_ff[0] <= '0;
         den_ff[0]  <= den_in;
         neg1_ff[0] <= n1_ff[DIFF_WIDTH-1] ^ det_ff[DIFF_WIDTH-1];
         neg2_ff[0] <= n2_ff[DIFF_WIDTH-1] ^ det_ff[DIFF_WIDTH-1];
         sing_ff[0] <= (det_ff == '0);

         for (int k = 0; k < QUOT_WIDTH; k++) begin
            rem1_ff[k+1] <= rem1_in[k];
            rem2_ff[k+1] <= rem2_in[k];
            num1_ff[k+1] <= num1_ff[k] << 1;
            num2_ff[k+1] <= num2_ff[k] << 1;
            quo1_ff[k+1] <= {quo1_ff[k][QUOT_WIDTH-2:0], bit1_in[k]};
            quo2_ff[k+1] <= {quo2_ff[k][QUOT_WIDTH-2:0], bit2_in[k]};
            den_ff[k+1]  <= den_ff[k];
            neg1_ff[k+1] <= neg1_ff[k];
            neg2_ff[k+1] <= neg2_ff[k];
            sing_ff[k+1] <= sing_ff[k];
         end

         c_sing_ff <= sing_ff[QUOT_WIDTH];
         if (sing_ff[QUOT_WIDTH]) begin
            c1_ff <= '0;
            c2_ff <= '0;
         end else begin
            c1_ff <= neg1_ff[QUOT_WIDTH] ? -q1_ext : q1_ext;
            c2_ff <= neg2_ff[QUOT_WIDTH] ? -q2_ext : q2_ext;
         end

         m_sing_ff <= c_sing_ff;
         m_c1_ff   <= c1_ff;
         m_c2_ff   <= c2_ff;
         t1x_ff    <= c1_ff * b1x_ff;
         t2x_ff    <= c2_ff * b2x_ff;
         t1y_ff    <= c1_ff * b1y_ff;
         t2y_ff    <= c2_ff * b2y_ff;

         f_res_ff.coef_first  <= m_c1_ff;
         f_res_ff.coef_second <= m_c2_ff;
         f_res_ff.point_x     <= POINT_WIDTH'(t1x_ff) + POINT_WIDTH'(t2x_ff);
         f_res_ff.point_y     <= POINT_WIDTH'(t1y_ff) + POINT_WIDTH'(t2y_ff);
         f_res_ff.singular    <= m_sing_ff;
      end
   end

   assign push = f_v_ff && en;
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (pop) begin
            rptr_ff <= ~rptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wptr_ff] <= f_res_ff;
      end
   end

   assign head            = fifo_ff[rptr_ff];
   assign rsp_valid       = (cnt_ff != 2'd0);
   assign rsp_coef_first  = head.coef_first;
   assign rsp_coef_second = head.coef_second;
   assign rsp_point_x     = head.point_x;
   assign rsp_point_y     = head.point_y;
   assign rsp_singular    = head.singular;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("Output queue count out of range.");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_coef_first == '0 && rsp_coef_second == '0
         && rsp_point_x == '0 && rsp_point_y == '0)
      else $error("Singular result item carries a nonzero value.");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("Result item valid right after reset.");

endmodule

`default_nettype wire

// ===== dv/babai_rounding_cvp_2d_tb.sv =====
// Testbench for the two-dimensional Babai rounding block.
// Drives target items under several bases and checks each result against a built-in predictor.
// Depends on bcvp_pkg and babai_rounding_cvp_2d.
`timescale 1ns / 1ps

module babai_rounding_cvp_2d_tb;
   import bcvp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [COORD_WIDTH-1:0] req_target_x = '0;
   logic signed [COORD_WIDTH-1:0] req_target_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [COEF_WIDTH-1:0] rsp_coef_first;
   logic signed [COEF_WIDTH-1:0] rsp_coef_second;
   logic signed [POINT_WIDTH-1:0] rsp_point_x;
   logic signed [POINT_WIDTH-1:0] rsp_point_y;
   logic rsp_singular;
   logic csr_we = 1'b0;
   logic [CSR_WIDTH-1:0] csr_index = '0;
   logic [COORD_WIDTH-1:0] csr_wdata = '0;

   babai_rounding_cvp_2d uut (.*);

   result_type pending_results[$];
   logic signed [COORD_WIDTH-1:0] basis_ax = 1, basis_ay = 0, basis_bx = 0, basis_by = 1;
   int error_count = 0;
   int result_count = 0;
   int singular_count = 0;
   int cycle_count = 0;
   bit idle_enable = 1'b1;

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic longint nearest_quotient(longint n, longint d);
      longint an, ad, q;
      an = n < 0 ? -n : n;
      ad = d < 0 ? -d : d;
      q = (2 * an + ad) / (2 * ad);
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   function automatic result_type closest_point(logic signed [COORD_WIDTH-1:0] tx,
                                                logic signed [COORD_WIDTH-1:0] ty);
      result_type r;
      longint det, c1, c2;
      det = longint'(basis_ax) * basis_by - longint'(basis_ay) * basis_bx;
      r = '0;
      if (det == 0) begin
         r.singular = 1'b1;
      end else begin
         c1 = nearest_quotient(longint'(tx) * basis_by - longint'(ty) * basis_bx, det);
         c2 = nearest_quotient(longint'(basis_ax) * ty - longint'(basis_ay) * tx, det);
         r.coef_first = c1[COEF_WIDTH-1:0];
         r.coef_second = c2[COEF_WIDTH-1:0];
         r.point_x = POINT_WIDTH'(c1 * basis_ax + c2 * basis_bx);
         r.point_y = POINT_WIDTH'(c1 * basis_ay + c2 * basis_by);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("Mismatch in %s at cycle %0d: got %0h, expected %0h", what, cycle_count, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (rsp_singular) singular_count++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", 0, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_coef_first !== want.coef_first)
               report_mismatch("coef_first", rsp_coef_first, want.coef_first);
            if (rsp_coef_second !== want.coef_second)
               report_mismatch("coef_second", rsp_coef_second, want.coef_second);
            if (rsp_point_x !== want.point_x)
               report_mismatch("point_x", rsp_point_x, want.point_x);
            if (rsp_point_y !== want.point_y)
               report_mismatch("point_y", rsp_point_y, want.point_y);
            if (rsp_singular !== want.singular)
               report_mismatch("singular", rsp_singular, want.singular);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || !idle_enable) begin
         rsp_ready <= !reset;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_target(logic signed [COORD_WIDTH-1:0] tx, logic signed [COORD_WIDTH-1:0] ty);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_target_x <= tx;
      req_target_y <= ty;
      pending_results.push_back(closest_point(tx, ty));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_basis(csr_index_type idx, logic [COORD_WIDTH-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_BASIS1_X: basis_ax = value;
         CSR_BASIS1_Y: basis_ay = value;
         CSR_BASIS2_X: basis_bx = value;
         default: basis_by = value;
      endcase
   endtask

   task automatic set_basis(logic [COORD_WIDTH-1:0] ax, logic [COORD_WIDTH-1:0] ay,
                            logic [COORD_WIDTH-1:0] bx, logic [COORD_WIDTH-1:0] by);
      wait_idle();
      write_basis(CSR_BASIS1_X, ax);
      write_basis(CSR_BASIS1_Y, ay);
      write_basis(CSR_BASIS2_X, bx);
      write_basis(CSR_BASIS2_Y, by);
      csr_we <= 1'b0;
   endtask

   task automatic test_reset_basis();
      send_target(16'sh7fff, 16'sh8000);
      send_target(16'sh8000, 16'sh7fff);
      send_target(0, 0);
      send_target(-1, 1);
   endtask

   task automatic test_half_rounding();
      set_basis(2, 0, 0, 2);
      send_target(1, -1);
      send_target(3, -3);
      send_target(-5, 5);
      set_basis(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
      send_target(16'sh7fff, 16'sh7fff);
      send_target(16'sh8000, 16'sh8000);
      send_target(16'sh8000, 16'sh7fff);
      set_basis(1, 1, 1, -1);
      send_target(1, 0);
      send_target(-1, 0);
      send_target(3, 2);
   endtask

   task automatic test_singular();
      set_basis(0, 0, 0, 0);
      send_target(16'sh7fff, 16'sh8000);
      set_basis(3, 6, -2, -4);
      send_target(5, 7);
      send_target(-32768, -32768);
      set_basis(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_target(12, -9);
   endtask

   task automatic test_random_bases();
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: set_basis($urandom, $urandom, $urandom, $urandom);
            1: set_basis($urandom_range(0, 15) - 8, $urandom_range(0, 15) - 8,
                         $urandom_range(0, 15) - 8, $urandom_range(0, 15) - 8);
            2: set_basis($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                         $urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200);
            default: set_basis($urandom_range(0, 3) - 2, $urandom_range(0, 3) - 2,
                               $urandom, $urandom);
         endcase
         if (phase == 11) idle_enable = 1'b0;
         for (int n = 0; n < 52; n++) begin
            if (n % 3 == 0)
               send_target($urandom_range(0, 31) - 16, $urandom_range(0, 31) - 16);
            else
               send_target($urandom, $urandom);
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_basis();
      test_half_rounding();
      test_singular();
      test_random_bases();
      wait_idle();
      $display("Checked %0d results (%0d singular) across directed and 12 random bases.",
               result_count, singular_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
